// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hw/rtl/bffi_pkg.sv =====
// Package: shared types and constants for the filtered id index
package bffi_pkg;
	localparam logic [31:0] SEED_A    = 32'hFBA4C795;
	localparam logic [31:0] SEED_B    = 32'h7F4A7C2B;
	localparam logic [31:0] FNV_PRIME = 32'h01000193;
	localparam int ID_BYTES = 32;
	localparam int ID_WORDS = 4;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_CHECK = 2'd1,
		ACT_FIND  = 2'd2,
		ACT_GET   = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] id_word0;
		logic [63:0] id_word1;
		logic [63:0] id_word2;
		logic [63:0] id_word3;
		logic [31:0] created_time;
		logic [7:0]  position;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] file_number;
		logic [31:0] entry_time;
		logic [8:0]  entry_count;
		logic        evicted;
		logic [31:0] evicted_file_number;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} hash_ctl_t;
endpackage

// ===== hw/rtl/bffi_stream_if.sv =====
// Interface: valid/ready channel carrying one payload
interface bffi_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bffi_hash.sv =====
// FNV-style hash of 32 id bytes, one byte per cycle, both seeds in parallel
module bffi_hash (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [255:0] id,
	output logic         busy,
	output logic         done,
	output logic [31:0]  hash_a,
	output logic [31:0]  hash_b
);
	logic [4:0]   idx_q;
	logic [255:0] sh_q;
	logic [31:0]  ha_q, hb_q;
	logic [7:0]   byte_w;
	logic [31:0]  ma, mb;

	assign byte_w = sh_q[255:248];
	assign ma = (ha_q ^ {24'd0, byte_w}) * bffi_pkg::FNV_PRIME;
	assign mb = (hb_q ^ {24'd0, byte_w}) * bffi_pkg::FNV_PRIME;
	assign hash_a = ha_q;
	assign hash_b = hb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			idx_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				idx_q <= '0;
				sh_q <= id;
				ha_q <= bffi_pkg::SEED_A;
				hb_q <= bffi_pkg::SEED_B;
			end else if (busy) begin
				ha_q <= ma;
				hb_q <= mb;
				sh_q <= {sh_q[247:0], 8'd0};
				idx_q <= idx_q + 5'd1;
				if (idx_q == 5'd31) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== hw/rtl/bloom_filtered_fifo_id_index.sv =====
// Top level: Bloom-screened FIFO index of 256-bit ids
// From accept to response valid a request passes hash, finish and output; an eviction adds
// an evict step. A filter pass with entries held adds a scan from the oldest entry, which
//   ends at a match with a read step; a get within range adds a read step.
// One transaction at a time; the next can be accepted from the cycle after the response.
// Reset clears filter bits, count, oldest pointer and file number; stores start undefined.
`include "assert_macros.svh"
module bloom_filtered_fifo_id_index #(
	parameter int RING_ENTRIES = 256,
	parameter int FILTER_BITS  = 512
) (
	input logic clk,
	input logic arst_n,
	bffi_stream_if.sink   req,
	bffi_stream_if.source rsp
);
	localparam int RW = $clog2(RING_ENTRIES);
	localparam int CW = $clog2(RING_ENTRIES + 1);
	localparam int FW = $clog2(FILTER_BITS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_HASH, ST_SCAN, ST_READ, ST_FIN, ST_EVICT, ST_OUT
	} state_t;

	state_t state_q;
	bffi_pkg::req_t req_q;
	bffi_pkg::rsp_t rsp_q;
	bffi_pkg::rsp_t rsp_n;
	logic [RW-1:0] oldest_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic [31:0]   next_fn_q;
	logic [FILTER_BITS-1:0] filt_q;
	logic [FILTER_BITS-1:0] filt_set;
	logic          found_q;
	logic          rd_pend_q;

	logic [255:0] id_mem [RING_ENTRIES];
	logic [31:0]  fn_mem [RING_ENTRIES];
	logic [31:0]  tm_mem [RING_ENTRIES];
	logic [255:0] id_rd_q;
	logic [31:0]  fn_rd_q, tm_rd_q;
	logic [RW-1:0] rd_addr;
	logic          wr_en;
	logic [RW-1:0] wr_addr;

	logic         h_start, h_busy, h_done;
	logic [31:0]  ha, hb;
	logic [255:0] id_w;
	logic [255:0] hash_id;
	logic         pass;
	logic         add_new;
	logic         get_hit;

	assign id_w = {req_q.id_word0, req_q.id_word1, req_q.id_word2, req_q.id_word3};
	assign hash_id = {req.data.id_word0, req.data.id_word1, req.data.id_word2,
		req.data.id_word3};

	bffi_hash u_hash (
		.clk(clk), .arst_n(arst_n), .start(h_start), .id(hash_id),
		.busy(h_busy), .done(h_done), .hash_a(ha), .hash_b(hb)
	);

	assign h_start = (state_q == ST_IDLE) && req.valid;
	assign pass = filt_q[ha[FW-1:0]] && filt_q[hb[FW-1:0]];
	assign filt_set = (FILTER_BITS'(1) << ha[FW-1:0]) | (FILTER_BITS'(1) << hb[FW-1:0]);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.data  = rsp_q;

	logic [RW-1:0] scan_slot, ins_slot, evict_slot;
	logic [RW:0]   sum_scan, sum_ins;
	logic [RW-1:0] evict_base;
	logic          full;
	assign full = (count_q == CW'(RING_ENTRIES));
	assign sum_scan = {1'b0, oldest_q} + (RW+1)'(scan_q);
	assign scan_slot = (sum_scan >= (RW+1)'(RING_ENTRIES)) ?
		RW'(sum_scan - (RW+1)'(RING_ENTRIES)) : sum_scan[RW-1:0];
	assign evict_slot = oldest_q;
	assign evict_base = full ? ((oldest_q == RW'(RING_ENTRIES - 1)) ? '0 : oldest_q + RW'(1))
		: oldest_q;
	assign sum_ins = {1'b0, evict_base} + (RW+1)'(full ? CW'(RING_ENTRIES - 1) : count_q);
	assign ins_slot = (sum_ins >= (RW+1)'(RING_ENTRIES)) ?
		RW'(sum_ins - (RW+1)'(RING_ENTRIES)) : sum_ins[RW-1:0];

	assign add_new = (req_q.action == bffi_pkg::ACT_ADD) && !found_q;
	assign get_hit = (32'(req_q.position) < 32'(count_q));
	assign wr_en = (state_q == ST_FIN) && add_new;
	assign wr_addr = ins_slot;
	assign rd_addr = (state_q == ST_FIN) ? evict_slot : scan_slot;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[wr_addr] <= id_w;
			fn_mem[wr_addr] <= next_fn_q;
			tm_mem[wr_addr] <= req_q.created_time;
		end
		id_rd_q <= id_mem[rd_addr];
		fn_rd_q <= fn_mem[rd_addr];
		tm_rd_q <= tm_mem[rd_addr];
	end

	always_comb begin
		rsp_n = '0;
		rsp_n.hit = found_q;
		rsp_n.entry_count = 9'(count_q);
		if (req_q.action == bffi_pkg::ACT_ADD) begin
			if (!found_q) begin
				rsp_n.file_number = next_fn_q;
				if (full)
					rsp_n.evicted = 1'b1;
				else
					rsp_n.entry_count = 9'(count_q + CW'(1));
			end
		end else if (req_q.action != bffi_pkg::ACT_CHECK && found_q) begin
			rsp_n.file_number = fn_rd_q;
			rsp_n.entry_time = tm_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oldest_q <= '0;
			count_q <= '0;
			next_fn_q <= '0;
			filt_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						req_q <= req.data;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (h_done) begin
						if (req_q.action == bffi_pkg::ACT_GET) begin
							if (get_hit) begin
								scan_q <= CW'(req_q.position);
								found_q <= 1'b1;
								state_q <= ST_READ;
							end else begin
								found_q <= 1'b0;
								state_q <= ST_FIN;
							end
						end else if (pass && count_q != '0) begin
							scan_q <= '0;
							found_q <= 1'b0;
							rd_pend_q <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							found_q <= 1'b0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					// memory read issued at scan_q, compared next cycle
					rd_pend_q <= 1'b1;
					if (rd_pend_q && id_rd_q == id_w) begin
						found_q <= 1'b1;
						scan_q <= scan_q - CW'(1);
						state_q <= ST_READ;
					end else if (rd_pend_q && scan_q == count_q) begin
						state_q <= ST_FIN;
					end else if (scan_q != count_q) begin
						scan_q <= scan_q + CW'(1);
					end
				end
				ST_READ: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					rsp_q <= rsp_n;
					if (add_new) begin
						next_fn_q <= next_fn_q + 32'd1;
						filt_q <= filt_q | filt_set;
						if (full)
							oldest_q <= evict_base;
						else
							count_q <= count_q + CW'(1);
					end
					state_q <= (add_new && full) ? ST_EVICT : ST_OUT;
				end
				ST_EVICT: begin
					// oldest slot was read on the write edge, before the overwrite
					rsp_q.evicted_file_number <= fn_rd_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, count_q <= CW'(RING_ENTRIES))
	`ASSERT_IMPL(a_ready_idle, clk, arst_n, req.ready, !rsp.valid)
	`ASSERT_IMPL(a_hash_idle, clk, arst_n, state_q == ST_IDLE, !h_busy)
	`ASSERT_NEXT(a_evict_full, clk, arst_n, rsp.valid && rsp.ready && rsp_q.evicted,
		count_q == CW'(RING_ENTRIES))
endmodule

// ===== verif/bffi_checker.sv =====
// Checker: predicts filtered id index responses and compares each transaction
`timescale 1ns / 100ps
module bffi_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input bffi_pkg::req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input bffi_pkg::rsp_t rsp_data,
	output int errors,
	output int pending
);
	localparam int RING = 256;
	localparam int FBITS = 512;

	logic [255:0] ring_id [RING];
	logic [31:0] ring_fnum [RING];
	logic [31:0] ring_time [RING];
	logic [7:0] head;
	int count;
	logic [31:0] next_fnum;
	logic [FBITS-1:0] filter;
	bffi_pkg::rsp_t expected_rsps[$];

	function automatic logic [31:0] fnv_hash(logic [255:0] id, logic [31:0] seed);
		logic [31:0] h;
		h = seed;
		for (int i = 0; i < bffi_pkg::ID_BYTES; i++) begin
			h = (h ^ {24'd0, id[255 - 8*i -: 8]}) * bffi_pkg::FNV_PRIME;
		end
		return h;
	endfunction

	function automatic int lookup_slot(logic [255:0] id);
		int a;
		int b;
		a = fnv_hash(id, bffi_pkg::SEED_A) % FBITS;
		b = fnv_hash(id, bffi_pkg::SEED_B) % FBITS;
		if (!(filter[a] && filter[b]))
			return -1;
		for (int i = 0; i < count; i++) begin
			if (ring_id[(head + i) % RING] == id)
				return (head + i) % RING;
		end
		return -1;
	endfunction

	function automatic bffi_pkg::rsp_t apply_request(bffi_pkg::req_t r);
		bffi_pkg::rsp_t o;
		logic [255:0] id;
		int s;
		o = '0;
		id = {r.id_word0, r.id_word1, r.id_word2, r.id_word3};
		unique case (bffi_pkg::action_t'(r.action))
			bffi_pkg::ACT_ADD: begin
				if (lookup_slot(id) >= 0) begin
					o.hit = 1'b1;
				end else begin
					if (count >= RING) begin
						o.evicted = 1'b1;
						o.evicted_file_number = ring_fnum[head];
						head = head + 8'd1;
						count = RING - 1;
					end
					o.file_number = next_fnum;
					s = (head + count) % RING;
					ring_id[s] = id;
					ring_fnum[s] = next_fnum;
					ring_time[s] = r.created_time;
					next_fnum = next_fnum + 32'd1;
					count++;
					filter[fnv_hash(id, bffi_pkg::SEED_A) % FBITS] = 1'b1;
					filter[fnv_hash(id, bffi_pkg::SEED_B) % FBITS] = 1'b1;
				end
			end
			bffi_pkg::ACT_CHECK: o.hit = lookup_slot(id) >= 0;
			bffi_pkg::ACT_FIND: begin
				s = lookup_slot(id);
				if (s >= 0) begin
					o.hit = 1'b1;
					o.file_number = ring_fnum[s];
					o.entry_time = ring_time[s];
				end
			end
			default: begin
				if (r.position < count) begin
					s = (head + r.position) % RING;
					o.hit = 1'b1;
					o.file_number = ring_fnum[s];
					o.entry_time = ring_time[s];
				end
			end
		endcase
		o.entry_count = count[8:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bffi_pkg::rsp_t e;
		if (!arst_n) begin
			head = '0;
			count = 0;
			next_fnum = '0;
			filter = '0;
			errors = 0;
			expected_rsps.delete();
			pending = 0;
		end else begin
			if (req_valid && req_ready)
				expected_rsps.push_back(apply_request(req_data));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %h", $time, rsp_data);
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					if (rsp_data !== e) begin
						$display("%0t: mismatch expected %h actual %h", $time, e, rsp_data);
						$display("  hit %b/%b fnum %h/%h time %h/%h cnt %0d/%0d ev %b/%b evn %h/%h",
							e.hit, rsp_data.hit, e.file_number, rsp_data.file_number,
							e.entry_time, rsp_data.entry_time, e.entry_count,
							rsp_data.entry_count, e.evicted, rsp_data.evicted,
							e.evicted_file_number, rsp_data.evicted_file_number);
						errors++;
					end
				end
			end
			pending = expected_rsps.size();
		end
	end
endmodule

// ===== verif/tb_bloom_filtered_fifo_id_index.sv =====
// Testbench top: stimulus for the filtered id index and the final verdict
`timescale 1ns / 100ps
module tb_bloom_filtered_fifo_id_index;
	localparam int RANDOM_ITEMS = 1930;
	localparam longint LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors;
	int pending;
	longint cycles = 0;
	int snk_idle = 0;
	bit no_idle = 1'b0;
	logic [255:0] known_ids[$];

	bffi_stream_if #(.payload_t(bffi_pkg::req_t)) req ();
	bffi_stream_if #(.payload_t(bffi_pkg::rsp_t)) rsp ();

	bloom_filtered_fifo_id_index i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	bffi_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_data(req.data),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_data(rsp.data),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// response side stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (snk_idle > 0) begin
				snk_idle <= snk_idle - 1;
				rsp.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				snk_idle <= $urandom_range(1, 18);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end else begin
			rsp.ready <= 1'b0;
		end
	end

	function automatic logic [255:0] rand_id();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom};
	endfunction

	// valid stays high after acceptance until the next transaction or an explicit drop
	task automatic send(bffi_pkg::action_t act, logic [255:0] id, logic [31:0] ctime,
		logic [7:0] pos);
		bffi_pkg::req_t r;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		r.action = act;
		{r.id_word0, r.id_word1, r.id_word2, r.id_word3} = id;
		r.created_time = ctime;
		r.position = pos;
		req.valid <= 1'b1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (act == bffi_pkg::ACT_ADD) begin
			known_ids.push_back(id);
			if (known_ids.size() > 400)
				void'(known_ids.pop_front());
		end
	endtask

	function automatic logic [255:0] pick_id();
		if (known_ids.size() > 0 && $urandom_range(0, 3) != 0)
			return known_ids[$urandom_range(0, known_ids.size() - 1)];
		return rand_id();
	endfunction

	initial begin
		int a;
		req.valid = 1'b0;
		req.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty lookups, extremes, duplicates, out-of-range gets
		send(bffi_pkg::ACT_GET, '0, '0, 8'd0);
		send(bffi_pkg::ACT_CHECK, '0, '0, '0);
		send(bffi_pkg::ACT_FIND, '1, '0, '0);
		send(bffi_pkg::ACT_ADD, '0, 32'd0, 8'hFF);
		send(bffi_pkg::ACT_ADD, '1, 32'hFFFF_FFFF, 8'd0);
		send(bffi_pkg::ACT_ADD, '0, 32'h1234_5678, 8'd0);
		send(bffi_pkg::ACT_CHECK, '0, '0, '0);
		send(bffi_pkg::ACT_FIND, '1, '1, '1);
		send(bffi_pkg::ACT_FIND, rand_id(), '0, '0);
		send(bffi_pkg::ACT_GET, '0, '0, 8'd1);
		send(bffi_pkg::ACT_GET, '0, '0, 8'd2);
		send(bffi_pkg::ACT_GET, '1, '1, 8'd255);
		send(bffi_pkg::ACT_ADD, {4{64'hA5A5_5A5A_0F0F_F0F0}}, 32'hDEAD_BEEF, 8'd0);
		send(bffi_pkg::ACT_FIND, {4{64'hA5A5_5A5A_0F0F_F0F0}}, '0, '0);
		send(bffi_pkg::ACT_ADD, {4{64'h5A5A_A5A5_F0F0_0F0F}}, 32'h0, 8'd0);
		send(bffi_pkg::ACT_GET, '0, '0, 8'd3);
		// hold off until every response has arrived
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// fill well past capacity so eviction and wrap of the oldest pointer happen
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > RANDOM_ITEMS - 150)
				no_idle = 1'b1;
			a = $urandom_range(0, 9);
			if (a < 4)
				send(bffi_pkg::ACT_ADD, $urandom_range(0, 5) == 0 ? pick_id() : rand_id(),
					$urandom, 8'($urandom));
			else if (a < 6)
				send(bffi_pkg::ACT_CHECK, pick_id(), $urandom, 8'($urandom));
			else if (a < 8)
				send(bffi_pkg::ACT_FIND, pick_id(), $urandom, 8'($urandom));
			else
				send(bffi_pkg::ACT_GET, rand_id(), $urandom, 8'($urandom));
		end
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== bloom_filtered_fifo_id_index.f =====
+incdir+hw/rtl
hw/rtl/bffi_pkg.sv
hw/rtl/bffi_stream_if.sv
hw/rtl/bffi_hash.sv
hw/rtl/bloom_filtered_fifo_id_index.sv
verif/bffi_checker.sv
verif/tb_bloom_filtered_fifo_id_index.sv
